FILE: rtl/core/barycentric_color_interpolator_assert.svh
// Assertion macros shared by the barycentric color interpolator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef BARYCENTRIC_COLOR_INTERPOLATOR_ASSERT_SVH
`define BARYCENTRIC_COLOR_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("barycentric color interpolator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("barycentric color interpolator check failed");

`endif

FILE: rtl/core/bci_pkg.sv
// Package for the barycentric color interpolator: widths, latencies and types.
// Used by every module in rtl/core; depends on nothing.
package bci_pkg;

    localparam int CW        = 13;
    localparam int DFW       = CW + 1;
    localparam int PW        = CW + DFW;
    localparam int SW        = PW + 2;
    localparam int AW        = SW;
    localparam int CHW       = 8;
    localparam int NCH       = 3;
    localparam int COLW      = CHW * NCH;
    localparam int MW        = AW + CHW;
    localparam int NW        = MW + 4;
    localparam int DW        = AW + 1;
    localparam int DIV_STEPS = CHW;
    localparam int AREA_LAT  = 3;
    localparam int BLEND_LAT = 2;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam int TOTAL_LAT = AREA_LAT + BLEND_LAT + DIV_LAT;

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [DFW-1:0] diff_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [SW-1:0]  sum_t;
    typedef logic [AW-1:0]         area_t;
    typedef logic [CHW-1:0]        chan_t;
    typedef logic [COLW-1:0]       color_t;
    typedef logic [MW-1:0]         mul_t;
    typedef logic [NW-1:0]         num_t;
    typedef logic [DW-1:0]         den_t;

endpackage

FILE: rtl/core/bci_area.sv
// Three-stage pipeline that forms the doubled absolute area of a triangle.
// Depends on bci_pkg.
module bci_area
    import bci_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  coord_t x0,
    input  coord_t y0,
    input  coord_t x1,
    input  coord_t y1,
    input  coord_t x2,
    input  coord_t y2,
    output area_t  area
);

    coord_t x0_reg, x1_reg, x2_reg;
    diff_t  d0_reg, d1_reg, d2_reg;
    prod_t  p0_reg, p1_reg, p2_reg;
    area_t  area_reg;
    sum_t   s_next;
    area_t  area_next;

    always_comb
    begin
        s_next    = SW'(p0_reg) + SW'(p1_reg) + SW'(p2_reg);
        area_next = s_next[SW-1] ? AW'(-s_next) : AW'(s_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= x0;
            x1_reg   <= x1;
            x2_reg   <= x2;
            d0_reg   <= DFW'(y1) - DFW'(y2);
            d1_reg   <= DFW'(y2) - DFW'(y0);
            d2_reg   <= DFW'(y0) - DFW'(y1);
            p0_reg   <= PW'(x0_reg) * PW'(d0_reg);
            p1_reg   <= PW'(x1_reg) * PW'(d1_reg);
            p2_reg   <= PW'(x2_reg) * PW'(d2_reg);
            area_reg <= area_next;
        end
    end

    assign area = area_reg;

endmodule

FILE: rtl/core/bci_blend.sv
// Two-stage pipeline that forms the rounded dividend per channel, the shared divisor and the degenerate flag.
// Depends on bci_pkg.
module bci_blend
    import bci_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  area_t               w0,
    input  area_t               w1,
    input  area_t               w2,
    input  area_t               full,
    input  color_t              color_a,
    input  color_t              color_b,
    input  color_t              color_c,
    output num_t  [NCH-1:0]     num,
    output den_t                den,
    output logic                degenerate
);

    mul_t [NCH-1:0] m0_reg, m1_reg, m2_reg;
    area_t          full_reg;
    num_t [NCH-1:0] num_reg;
    num_t [NCH-1:0] num_next;
    den_t           den_reg;
    logic           deg_reg;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            num_next[c] = ((NW'(m0_reg[c]) + NW'(m1_reg[c]) + NW'(m2_reg[c])) << 1)
                        + NW'(full_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                m0_reg[c] <= MW'(w0) * MW'(color_a[c*CHW +: CHW]);
                m1_reg[c] <= MW'(w1) * MW'(color_b[c*CHW +: CHW]);
                m2_reg[c] <= MW'(w2) * MW'(color_c[c*CHW +: CHW]);
            end
            full_reg <= full;
            num_reg  <= num_next;
            den_reg  <= DW'(full_reg) << 1;
            deg_reg  <= (full_reg == '0);
        end
    end

    assign num        = num_reg;
    assign den        = den_reg;
    assign degenerate = deg_reg;

endmodule

FILE: rtl/core/bci_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating at 255.
// Depends on bci_pkg.
module bci_div
    import bci_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  num_t  num,
    input  den_t  den,
    output chan_t quo
);

    num_t  rem_reg [0:DIV_STEPS];
    den_t  d_reg   [0:DIV_STEPS];
    chan_t q_reg   [0:DIV_STEPS];
    logic  ovf_reg [0:DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num >= (NW'(den) << DIV_STEPS));
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        localparam int SH = DIV_STEPS - k;
        num_t  trial;
        logic  take;
        num_t  rem_next;
        chan_t q_next;

        always_comb
        begin
            trial    = NW'(d_reg[k-1]) << SH;
            take     = (rem_reg[k-1] >= trial);
            rem_next = take ? (rem_reg[k-1] - trial) : rem_reg[k-1];
            q_next   = q_reg[k-1];
            q_next[SH] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_next;
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = ovf_reg[DIV_STEPS] ? '1 : q_reg[DIV_STEPS];

endmodule

FILE: rtl/core/barycentric_color_interpolator.sv
// Barycentric color interpolator: one pixel color per transfer, fully pipelined.
// Depends on bci_pkg, bci_area, bci_blend, bci_div and the assertion header.
// The block accepts one transfer every clock while in_stall is low; three stages
// form the four triangle areas, two form the weighted channel sums, and nine
// divide by the full area one quotient bit at a time.
// When a finished result waits on out_stall the whole pipeline holds and in_stall rises.
`include "barycentric_color_interpolator_assert.svh"

module barycentric_color_interpolator
    import bci_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  coord_t a_x,
    input  coord_t a_y,
    input  coord_t b_x,
    input  coord_t b_y,
    input  coord_t c_x,
    input  coord_t c_y,
    input  coord_t p_x,
    input  coord_t p_y,
    input  color_t color_a,
    input  color_t color_b,
    input  color_t color_c,
    output logic   out_valid,
    input  logic   out_stall,
    output chan_t  red,
    output chan_t  green,
    output chan_t  blue,
    output logic   degenerate
);

    logic           en;
    logic [TOTAL_LAT-1:0] vld_reg;
    color_t         ca_reg [0:AREA_LAT-1];
    color_t         cb_reg [0:AREA_LAT-1];
    color_t         cc_reg [0:AREA_LAT-1];
    logic           deg_reg [0:DIV_LAT-1];
    area_t          full, w0, w1, w2;
    num_t [NCH-1:0] num;
    den_t           den;
    logic           blend_deg;
    chan_t [NCH-1:0] quo;

    assign en       = !(vld_reg[TOTAL_LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg[0]  <= color_a;
            cb_reg[0]  <= color_b;
            cc_reg[0]  <= color_c;
            deg_reg[0] <= blend_deg;
            for (int i = 1; i < AREA_LAT; i++)
            begin
                ca_reg[i] <= ca_reg[i-1];
                cb_reg[i] <= cb_reg[i-1];
                cc_reg[i] <= cc_reg[i-1];
            end
            for (int i = 1; i < DIV_LAT; i++)
            begin
                deg_reg[i] <= deg_reg[i-1];
            end
        end
    end

    bci_area u_full (.clk(clk), .en(en), .x0(a_x), .y0(a_y), .x1(b_x), .y1(b_y),
                     .x2(c_x), .y2(c_y), .area(full));
    bci_area u_w0   (.clk(clk), .en(en), .x0(p_x), .y0(p_y), .x1(b_x), .y1(b_y),
                     .x2(c_x), .y2(c_y), .area(w0));
    bci_area u_w1   (.clk(clk), .en(en), .x0(a_x), .y0(a_y), .x1(p_x), .y1(p_y),
                     .x2(c_x), .y2(c_y), .area(w1));
    bci_area u_w2   (.clk(clk), .en(en), .x0(a_x), .y0(a_y), .x1(b_x), .y1(b_y),
                     .x2(p_x), .y2(p_y), .area(w2));

    bci_blend u_blend (
        .clk        (clk),
        .en         (en),
        .w0         (w0),
        .w1         (w1),
        .w2         (w2),
        .full       (full),
        .color_a    (ca_reg[AREA_LAT-1]),
        .color_b    (cb_reg[AREA_LAT-1]),
        .color_c    (cc_reg[AREA_LAT-1]),
        .num        (num),
        .den        (den),
        .degenerate (blend_deg)
    );

    for (genvar c = 0; c < NCH; c++)
    begin : g_lane
        bci_div u_div (.clk(clk), .en(en), .num(num[c]), .den(den), .quo(quo[c]));
    end

    assign out_valid  = vld_reg[TOTAL_LAT-1];
    assign degenerate = deg_reg[DIV_LAT-1];
    assign red        = degenerate ? '0 : quo[CH_RED];
    assign green      = degenerate ? '0 : quo[CH_GREEN];
    assign blue       = degenerate ? '0 : quo[CH_BLUE];

    `BCI_ASSERT_NOW(a_deg_black, out_valid && degenerate, red == '0 && green == '0 && blue == '0)
    `BCI_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    `BCI_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)

endmodule

FILE: tb/barycentric_color_interpolator_test.sv
// Self-checking testbench for barycentric_color_interpolator.
// Drives directed and random triangles through the valid/stall channels and checks
// each transfer against a listed or integer-model pixel; uses bci_pkg and the RTL.
`timescale 1ns / 100ps

module barycentric_color_interpolator_test
    import bci_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 850;

    typedef struct packed {
        coord_t ax, ay, bx, by, cx, cy, px, py;
        color_t ca, cb, cc;
    } tri_t;

    typedef struct packed {
        chan_t r, g, b;
        logic  degen;
    } pixel_t;

    typedef struct {
        tri_t   t;
        logic   known;
        pixel_t want;
    } row_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    coord_t a_x = '0, a_y = '0, b_x = '0, b_y = '0, c_x = '0, c_y = '0, p_x = '0, p_y = '0;
    color_t color_a = '0, color_b = '0, color_c = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    chan_t  red, green, blue;
    logic   degenerate;

    pixel_t pending_pixels[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    bit     calm = 1'b0;
    row_t   rows[$];

    always #6 clk = ~clk;

    barycentric_color_interpolator u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .c_x(c_x), .c_y(c_y),
        .p_x(p_x), .p_y(p_y), .color_a(color_a), .color_b(color_b), .color_c(color_c),
        .out_valid(out_valid), .out_stall(out_stall), .red(red), .green(green),
        .blue(blue), .degenerate(degenerate)
    );

    function automatic longint twice_area(longint x0, longint y0, longint x1, longint y1,
                                          longint x2, longint y2);
        longint s;
        s = x0 * (y1 - y2) + x1 * (y2 - y0) + x2 * (y0 - y1);
        return (s < 0) ? -s : s;
    endfunction

    function automatic pixel_t shade_pixel(tri_t t);
        pixel_t px;
        longint full, w0, w1, w2, num, q;
        int sh;
        full = twice_area(t.ax, t.ay, t.bx, t.by, t.cx, t.cy);
        w0 = twice_area(t.px, t.py, t.bx, t.by, t.cx, t.cy);
        w1 = twice_area(t.ax, t.ay, t.px, t.py, t.cx, t.cy);
        w2 = twice_area(t.ax, t.ay, t.bx, t.by, t.px, t.py);
        px = '0;
        if (full == 0)
        begin
            px.degen = 1'b1;
            return px;
        end
        for (int ch = 0; ch < NCH; ch++)
        begin
            sh = ch * CHW;
            num = w0 * longint'((t.ca >> sh) & 8'hFF) + w1 * longint'((t.cb >> sh) & 8'hFF)
                + w2 * longint'((t.cc >> sh) & 8'hFF);
            q = (2 * num + full) / (2 * full);
            if (q > 255)
                q = 255;
            if (ch == CH_RED)
                px.r = q[7:0];
            else if (ch == CH_GREEN)
                px.g = q[7:0];
            else
                px.b = q[7:0];
        end
        return px;
    endfunction

    function automatic coord_t rand_coord(int span);
        if (span == 0)
            return coord_t'($urandom);
        return coord_t'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic tri_t rand_tri();
        tri_t t;
        int span;
        int mode;
        mode = $urandom_range(0, 9);
        span = (mode < 3) ? 0 : (mode < 7) ? 300 : 40;
        t.ax = rand_coord(span);
        t.ay = rand_coord(span);
        t.bx = rand_coord(span);
        t.by = rand_coord(span);
        t.cx = rand_coord(span);
        t.cy = rand_coord(span);
        if (mode == 9)
        begin
            t.cx = t.bx;
            t.cy = t.by;
        end
        if (mode >= 5 && mode <= 7)
        begin
            t.px = coord_t'((3 * int'(t.ax) + 2 * int'(t.bx) + int'(t.cx)) / 6);
            t.py = coord_t'((3 * int'(t.ay) + 2 * int'(t.by) + int'(t.cy)) / 6);
        end
        else
        begin
            t.px = rand_coord(span);
            t.py = rand_coord(span);
        end
        t.ca = color_t'($urandom);
        t.cb = color_t'($urandom);
        t.cc = color_t'($urandom);
        return t;
    endfunction

    function automatic tri_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                      int px, int py, int ca, int cb, int cc);
        tri_t t;
        t.ax = coord_t'(ax); t.ay = coord_t'(ay);
        t.bx = coord_t'(bx); t.by = coord_t'(by);
        t.cx = coord_t'(cx); t.cy = coord_t'(cy);
        t.px = coord_t'(px); t.py = coord_t'(py);
        t.ca = color_t'(ca); t.cb = color_t'(cb); t.cc = color_t'(cc);
        return t;
    endfunction

    task automatic add_row(tri_t t, logic known, pixel_t want);
        row_t r;
        r.t = t;
        r.known = known;
        r.want = want;
        rows = {rows, r};
    endtask

    task automatic send_triangle(tri_t t, logic known, pixel_t want);
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y, color_a, color_b, color_c} <= t;
        pending_pixels = {pending_pixels, (known ? want : shade_pixel(t))};
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    always @(negedge clk)
        if (rst_n)
            out_stall <= !calm && ($urandom_range(0, 99) < 14);

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = {red, green, blue, degenerate};
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: %h", got);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected r=%0d g=%0d b=%0d d=%0b, ",
                                  "got r=%0d g=%0d b=%0d d=%0b"},
                                 want.r, want.g, want.b, want.degen,
                                 got.r, got.g, got.b, got.degen);
                end
            end
        end
    end

    initial
    begin
        pixel_t black;
        pixel_t white;
        pixel_t none;
        black = '0;
        black.degen = 1'b1;
        white = {8'hFF, 8'hFF, 8'hFF, 1'b0};
        none = '0;
        add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 1'b1,
                black);
        add_row(make_tri(-4096, -4096, 0, 0, 4095, 4095, 1, 2, 24'h123456, 24'hABCDEF, 24'hFFFFFF),
                1'b1, black);
        add_row(make_tri(0, 0, 10, 0, 0, 10, 0, 0, 24'hFFFFFF, 24'h000000, 24'h000000), 1'b1,
                white);
        add_row(make_tri(0, 0, 10, 0, 0, 10, 10, 0, 24'h000000, 24'h00FF00, 24'h000000), 1'b1,
                {8'h00, 8'hFF, 8'h00, 1'b0});
        add_row(make_tri(0, 0, 10, 0, 0, 10, 0, 10, 24'h000000, 24'h000000, 24'h0000FF), 1'b1,
                {8'h00, 8'h00, 8'hFF, 1'b0});
        add_row(make_tri(-4096, -4096, 4095, -4096, -4096, 4095, 0, 0, 24'hFFFFFF, 24'hFFFFFF,
                         24'hFFFFFF), 1'b1, white);
        add_row(make_tri(-4096, -4096, 4095, -4096, -4096, 4095, 4095, 4095, 24'hFFFFFF,
                         24'hFFFFFF, 24'hFFFFFF), 1'b1, white);
        add_row(make_tri(4095, 4095, -4096, 4095, 4095, -4096, -4096, -4096, 24'h000000,
                         24'h000000, 24'h000000), 1'b1, '0);
        add_row(make_tri(0, 0, 1, 0, 0, 1, 4095, -4096, 24'h808080, 24'h7F7F7F, 24'h010101),
                1'b0, none);
        add_row(make_tri(0, 0, 2, 0, 0, 2, 1, 0, 24'h000000, 24'h000001, 24'h000000), 1'b0,
                none);
        add_row(make_tri(0, 0, 3, 0, 0, 3, 1, 1, 24'hFF0000, 24'h00FF00, 24'h0000FF), 1'b0,
                none);
        add_row(make_tri(-5, -7, 4095, 3, 17, 4095, 100, 200, 24'h5A5A5A, 24'hA5A5A5, 24'h3C3C3C),
                1'b0, none);
        add_row(make_tri(1, 1, 1, 1, 9, 9, 3, 3, 24'h111111, 24'h222222, 24'h333333), 1'b1,
                black);
        add_row(make_tri(0, 0, 4, 4, 8, 8, 2, 5, 24'hFFFFFF, 24'h000000, 24'hFFFFFF), 1'b1,
                black);
        add_row(make_tri(-4096, 4095, 4095, -4096, 0, 0, -1, -1, 24'hC0FFEE, 24'h0BAD00,
                         24'hF00D42), 1'b0, none);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_triangle(rows[i].t, rows[i].known, rows[i].want);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 300 && n < 420);
            send_triangle(rand_tri(), 1'b0, none);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (4 * TOTAL_LAT) @(negedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
